/* design/maf_pkg.sv */
`default_nettype none

package maf_pkg;

	// Default storage and sample sizes
	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 16;

	// Window length register: fixed field width and its value after reset
	localparam int             LEN_BITS  = 7;
	localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(16);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic cfg_write;  // take a new window length and clear the filter
		logic capture;    // latch the accepted sample
		logic read_old;   // read the entry about to be replaced
		logic update;     // update the running sum, write the entry, advance
		logic div_setup;  // load the magnitude of the sum into the divider
		logic div_step;   // one restoring division step
		logic load_out;   // place the signed quotient in the output register
	} maf_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_last;   // the current division step is the final one
	} maf_status_t;

endpackage

`default_nettype wire

/* design/maf_ram.sv */
`default_nettype none

module maf_ram #(
	parameter int WIDTH = maf_pkg::SAMPLE_BITS,
	parameter int DEPTH = maf_pkg::WINDOW_MAX
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/maf_datapath.sv */
`default_nettype none

module maf_datapath #(
	parameter int WINDOW_MAX  = maf_pkg::WINDOW_MAX,
	parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire maf_pkg::maf_cmd_t                      cmd,
	output maf_pkg::maf_status_t                        status,
	input  wire logic [maf_pkg::LEN_BITS-1:0]           window_len,
	input  wire logic signed [SAMPLE_BITS-1:0]          sample,
	output logic signed [SAMPLE_BITS-1:0]               average
);

	localparam int LEN_BITS = maf_pkg::LEN_BITS;
	localparam int POS_BITS = $clog2(WINDOW_MAX);
	localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int CNT_BITS = $clog2(SUM_BITS + 1);

	logic [LEN_BITS-1:0]           len_q;
	logic [LEN_BITS-1:0]           len_wr;
	logic [POS_BITS-1:0]           pos_q;
	logic                          wrapped_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic signed [SUM_BITS-1:0]    sum_nxt;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] old_val;
	logic [SAMPLE_BITS-1:0]        ram_rdata;
	logic [31:0]                   pos_inc;
	logic                          pos_wrap;
	logic                          neg_q;
	logic [SUM_BITS-1:0]           quot_q;
	logic [SUM_BITS-1:0]           quot_signed;
	logic [LEN_BITS-1:0]           rem_q;
	logic [LEN_BITS:0]             trial;
	logic                          trial_fits;
	logic [CNT_BITS-1:0]           cnt_q;

	// Window store: read before the update, written during it
	maf_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_store (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(pos_q),
		.wdata(sample_q),
		.re   (cmd.read_old),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	// A written length of zero means one; anything above the store depth is clamped
	always_comb begin
		if (window_len == '0) begin
			len_wr = LEN_BITS'(1);
		end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
			len_wr = LEN_BITS'(WINDOW_MAX);
		end else begin
			len_wr = window_len;
		end
	end

	// Entries are written in order from position zero after a clear, so until the
	// position first wraps the entry being replaced still holds zero.
	assign old_val  = wrapped_q ? signed'(ram_rdata) : '0;
	assign sum_nxt  = sum_q + SUM_BITS'(sample_q) - SUM_BITS'(old_val);
	assign pos_inc  = 32'(pos_q) + 32'd1;
	assign pos_wrap = (pos_inc >= 32'(len_q)) || (pos_inc >= 32'(WINDOW_MAX));

	// Window state: length, position, fill flag and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= maf_pkg::LEN_RESET;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else if (cmd.cfg_write) begin
			len_q     <= len_wr;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_nxt;
			if (pos_wrap) begin
				pos_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				pos_q <= POS_BITS'(pos_inc);
			end
		end
	end

	// Sample holding register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
	end

	// Restoring division of the sum magnitude by the window length, one bit a step
	assign trial      = {rem_q, quot_q[SUM_BITS-1]};
	assign trial_fits = trial >= {1'b0, len_q};

	always_ff @(posedge clk) begin
		if (cmd.div_setup) begin
			neg_q  <= sum_q[SUM_BITS-1];
			quot_q <= sum_q[SUM_BITS-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
			rem_q  <= '0;
			cnt_q  <= CNT_BITS'(SUM_BITS);
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[SUM_BITS-2:0], trial_fits};
			rem_q  <= trial_fits ? LEN_BITS'(trial - {1'b0, len_q}) : LEN_BITS'(trial);
			cnt_q  <= cnt_q - CNT_BITS'(1);
		end
	end

	assign status.div_last = (cnt_q == CNT_BITS'(1));

	// Quotient truncated toward zero: restore the sign of the sum
	assign quot_signed = neg_q ? (-quot_q) : quot_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			average <= signed'(quot_signed[SAMPLE_BITS-1:0]);
		end
	end

endmodule

`default_nettype wire

/* design/maf_ctrl.sv */
`default_nettype none

module maf_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_ready,
	output logic                      average_valid,
	input  wire logic                 average_ready,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	output maf_pkg::maf_cmd_t         cmd,
	input  wire maf_pkg::maf_status_t status
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_READ   = 6'b000010,
		ST_UPDATE = 6'b000100,
		ST_SETUP  = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_FINISH = 6'b100000
	} maf_state_t;

	maf_state_t state_q;
	maf_state_t state_nxt;
	logic       out_free;

	// A configuration request takes precedence over a sample in the idle state
	assign cfg_ready    = (state_q == ST_IDLE);
	assign sample_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign out_free     = !average_valid || average_ready;

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.cfg_write = cfg_valid;
				cmd.capture   = sample_valid && !cfg_valid;
				if (sample_valid && !cfg_valid) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read_old = 1'b1;
				state_nxt    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.div_setup = 1'b1;
				state_nxt     = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_valid <= 1'b0;
		end else if (cmd.load_out) begin
			average_valid <= 1'b1;
		end else if (average_ready) begin
			average_valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* design/moving_average_filter.sv */
`default_nettype none

// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_ready   sample  (SAMPLE_BITS, signed)
// average   out        average_valid / average_ready average (SAMPLE_BITS, signed)
// cfg       in         cfg_valid / cfg_ready         window_len (7 bits, unsigned)
//
// Each sample passes through the read, update, setup, divide and finish states; the
// divide state is the bit-serial divider, which runs one step per bit of the running sum.
// Reset clears the sum and write position and sets the window length to 16; the
// store needs no clearing pass, as entries not yet rewritten since a clear read as zero.
// A new sample is taken while the previous result still waits in the output register;
// the result of that sample is held back until the output register is free.

module moving_average_filter #(
	parameter int WINDOW_MAX  = maf_pkg::WINDOW_MAX,
	parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample,
	output logic                                   average_valid,
	input  wire logic                              average_ready,
	output logic signed [SAMPLE_BITS-1:0]          average,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [maf_pkg::LEN_BITS-1:0]      window_len
);

	maf_pkg::maf_cmd_t    cmd;
	maf_pkg::maf_status_t status;

	// Sequencing of each request
	maf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.average_valid(average_valid),
		.average_ready(average_ready),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cmd          (cmd),
		.status       (status)
	);

	// Window store, running sum and divider
	maf_datapath #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.window_len(window_len),
		.sample    (sample),
		.average   (average)
	);

	// The block is busy for the whole of a sample once it has been taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready && !cfg_ready)
		else $error("request accepted while a sample is being processed");

	// A sample and a configuration write are never taken together.
	a_no_dual_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample_valid && sample_ready && cfg_valid && cfg_ready))
		else $error("sample and configuration accepted in the same cycle");

	// Loading a result always leaves the output register occupied.
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> average_valid)
		else $error("result loaded but not presented");

	// The divider starts stepping straight after it is loaded.
	a_setup_then_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_setup |=> cmd.div_step)
		else $error("division set up but not started");

endmodule

`default_nettype wire

/* tb/moving_average_checker.sv */
`timescale 1ns / 100ps

module moving_average_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	input  logic                                sample_ready,
	input  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                average_valid,
	input  logic                                average_ready,
	input  logic signed [maf_pkg::SAMPLE_BITS-1:0] average,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [maf_pkg::LEN_BITS-1:0]        window_len,
	output int                                  mismatches,
	output int                                  pending
);

	localparam int WINDOW_MAX  = maf_pkg::WINDOW_MAX;
	localparam int SAMPLE_BITS = maf_pkg::SAMPLE_BITS;
	localparam int LEN_BITS    = maf_pkg::LEN_BITS;
	localparam int SHOWN_MAX   = 10;

	// Own copy of the filter: stored samples, next slot, running sum and window length.
	logic signed [SAMPLE_BITS-1:0] taps [WINDOW_MAX];
	logic [5:0]                    head;
	logic signed [21:0]            total;
	logic [LEN_BITS-1:0]           span;

	logic signed [SAMPLE_BITS-1:0] expected_averages [$];
	int                            fault_count;

	function automatic void clear_window();
		for (int i = 0; i < WINDOW_MAX; i++)
			taps[i] = '0;
		head  = '0;
		total = '0;
	endfunction

	// A length of zero counts as one, and anything above the store size as the store size.
	function automatic logic [LEN_BITS-1:0] clamp_length(input logic [LEN_BITS-1:0] raw);
		if (raw == 0)
			return LEN_BITS'(1);
		if (int'(raw) > WINDOW_MAX)
			return LEN_BITS'(WINDOW_MAX);
		return raw;
	endfunction

	// Replace the oldest sample, update the sum and return the average, truncated toward zero.
	function automatic logic signed [SAMPLE_BITS-1:0] advance_window(
		input logic signed [SAMPLE_BITS-1:0] s
	);
		int     slot;
		longint quotient;
		slot = int'(head);
		if (slot >= int'(span))
			slot = 0;
		total = total + s - taps[slot];
		taps[slot] = s;
		slot++;
		if (slot >= int'(span))
			slot = 0;
		head = 6'(slot);
		quotient = longint'(total) / longint'(span);
		return SAMPLE_BITS'(quotient);
	endfunction

	// Follow every accepted request on the three channels.
	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_BITS-1:0] want;
		if (!arst_n) begin
			clear_window();
			span = maf_pkg::LEN_RESET;
			expected_averages.delete();
			fault_count = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				span = clamp_length(window_len);
				clear_window();
			end
			if (average_valid && average_ready) begin
				if (expected_averages.size() == 0) begin
					if (fault_count < SHOWN_MAX)
						$display("%0t: average %0d arrived with none expected", $realtime, average);
					fault_count++;
				end else begin
					want = expected_averages.pop_front();
					if (want !== average) begin
						if (fault_count < SHOWN_MAX)
							$display("%0t: average mismatch: expected %0d, got %0d",
								$realtime, want, average);
						fault_count++;
					end
				end
			end
			if (sample_valid && sample_ready)
				expected_averages.push_back(advance_window(sample));
			mismatches <= fault_count;
			pending    <= expected_averages.size();
		end
	end

endmodule

/* tb/tb_moving_average_filter.sv */
`timescale 1ns / 100ps

module tb_moving_average_filter;

	localparam int SAMPLE_BITS  = maf_pkg::SAMPLE_BITS;
	localparam int LEN_BITS     = maf_pkg::LEN_BITS;
	localparam int RANDOM_ITEMS = 700;
	localparam int HOLD_CYCLES  = 600;
	localparam int IDLE_LIMIT   = 5000;
	localparam int TAIL_CYCLES  = 40;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                          clk;
	logic                          arst_n;
	logic                          sample_valid;
	logic                          sample_ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          average_valid;
	logic                          average_ready;
	logic signed [SAMPLE_BITS-1:0] average;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [LEN_BITS-1:0]           window_len;
	int                            mismatches;
	int                            pending;

	int burst_left;
	bit steady;
	bit hold_request;

	logic [LEN_BITS-1:0] length_table [7] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd3};

	moving_average_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample        (sample),
		.average_valid (average_valid),
		.average_ready (average_ready),
		.average       (average),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_len    (window_len)
	);

	moving_average_checker window_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample        (sample),
		.average_valid (average_valid),
		.average_ready (average_ready),
		.average       (average),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_len    (window_len),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one sample; between bursts the request line may drop for a random gap.
	task automatic put_sample(input logic signed [SAMPLE_BITS-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				sample_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		sample_valid <= 1'b1;
		sample       <= v;
		do @(posedge clk); while (!sample_ready);
	endtask

	// Withdraw the sample request and wait until every average has come back.
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_BITS-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid  <= 1'b1;
		window_len <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The receiver stalls on a rotating pattern, or for a long stretch when asked to.
	initial begin
		logic [15:0] pattern;
		int          tick;
		average_ready = 1'b0;
		pattern = 16'hFFFF;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				average_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				if (tick % 64 == 0)
					pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
				average_ready <= pattern[tick % 16];
				tick++;
			end
		end
	end

	// Give up when no request has been accepted on any channel for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (average_valid && average_ready) ||
				(cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int                            sent;
		int                            phase;
		int                            run_len;
		logic [LEN_BITS-1:0]           setting;
		logic signed [SAMPLE_BITS-1:0] v;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		window_len   = '0;
		burst_left   = 0;
		steady       = 1'b0;
		hold_request = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Window of sixteen from reset: fill with the top value, then the extremes and zero.
		for (int i = 0; i < 16; i++)
			put_sample(SAMPLE_MAX);
		put_sample(SAMPLE_MIN);
		put_sample(-1);
		put_sample(1);
		put_sample(0);

		// A length of zero acts as one.
		write_length(7'd0);
		put_sample(-1);
		put_sample(SAMPLE_MAX);

		// An oversized length acts as the full store; a negative sum rounds toward zero.
		write_length(7'd127);
		put_sample(SAMPLE_MIN);
		put_sample(-1);
		put_sample(5);

		// Random phases, each under a fresh window length.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			setting = (phase < 7) ? length_table[phase] : LEN_BITS'($urandom_range(0, 127));
			write_length(setting);
			steady = ($urandom_range(0, 3) == 0);
			if (phase == 1)
				hold_request = 1'b1;
			run_len = $urandom_range(20, 120);
			for (int i = 0; i < run_len; i++) begin
				case ($urandom_range(0, 3))
					0:       v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
					1:       v = SAMPLE_BITS'(int'($urandom_range(0, 80)) - 40);
					default: v = SAMPLE_BITS'($urandom);
				endcase
				put_sample(v);
			end
			sent += run_len;
			phase++;
		end

		// Let the last averages come back, then a short quiet tail.
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
